// File: design/station_occupancy_table_unit_assert.svh
// assertion macros for the station occupancy table
`ifndef STATION_OCCUPANCY_TABLE_UNIT_ASSERT_SVH
`define STATION_OCCUPANCY_TABLE_UNIT_ASSERT_SVH

// clocked check, off while reset is held
`define SOTU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define SOTU_ASSERT_IMP(lbl, ante, cons, msg) \
  `SOTU_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define SOTU_ASSERT_NXT(lbl, ante, cons, msg) \
  `SOTU_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: design/sotu_pkg.sv
package sotu_pkg;

  // table geometry
  localparam int NUM_LABS     = 4;
  localparam int MAX_STATIONS = 64;
  localparam int NUM_REGS     = 4;
  localparam int NUM_SLOTS    = NUM_LABS * MAX_STATIONS;
  localparam int ADDR_W       = $clog2(NUM_SLOTS);

  // field widths
  localparam int ID_W     = 17;
  localparam int LAB_W    = 2;
  localparam int STA_W    = 6;
  localparam int CNT_W    = 7;
  localparam int LABI_W   = $clog2(NUM_LABS + 1);
  localparam int REGI_W   = $clog2(NUM_REGS);
  localparam int PADDR_W  = $clog2(NUM_REGS * 4);
  localparam int PDATA_W  = 32;

  typedef enum logic [1:0] {
    CMD_LOGIN  = 2'd0,
    CMD_LOGOFF = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BUSY      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_BAD       = 2'd3
  } status_e;

  typedef logic [CNT_W-1:0] lab_cnt_t;
  typedef lab_cnt_t [NUM_REGS-1:0] lab_cnt_arr_t;

  // one result item
  typedef struct packed {
    logic [1:0]       status;
    logic [LAB_W-1:0] lab;
    logic [STA_W-1:0] sta;
    logic [ID_W-1:0]  occ;
  } result_t;

  // configured stations of a lab, clipped to MAX_STATIONS
  function automatic lab_cnt_t stations_in_lab(lab_cnt_arr_t cnt, logic [LABI_W-1:0] lab);
    lab_cnt_t n;
    n = '0;
    if (32'(lab) < NUM_REGS && 32'(lab) < NUM_LABS) begin
      n = cnt[lab[REGI_W-1:0]];
      if (32'(n) > MAX_STATIONS) begin
        n = CNT_W'(MAX_STATIONS);
      end
    end
    return n;
  endfunction

  // slot address of a lab and station
  function automatic logic [ADDR_W-1:0] slot_addr(logic [LAB_W-1:0] lab,
                                                  logic [STA_W-1:0] sta);
    return ADDR_W'(32'(lab) * MAX_STATIONS + 32'(sta));
  endfunction

endpackage

// File: design/station_occupancy_table_unit.sv
// channel  | dir | payload                                      | handshake
// ---------+-----+----------------------------------------------+---------------------
// input    | in  | cmd, user_id, lab_number, station_number     | in_valid / in_ready
// result   | out | status, found_lab, found_station, occupant_id| out_valid / out_ready
// config   | in  | paddr, pwdata, prdata                        | psel/penable/pwrite
//
// login: from accept to output register through check, read and decide, hand over
// logoff/search: up to S slot reads, S the sum of configured stations (max 256): one
//   slot read per cycle, a step per lab to move on, then close and hand over
// reset: occupancy flags are flip-flops and clear at once, the id memory is not reset
// stalls: one item at a time; the next is taken once the result sits in the output
//   register, which holds it for as long as out_ready is low
`include "station_occupancy_table_unit_assert.svh"

module station_occupancy_table_unit import sotu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [ID_W-1:0]    user_id_i,
  input  logic [LAB_W-1:0]   lab_number_i,
  input  logic [STA_W-1:0]   station_number_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [LAB_W-1:0]   found_lab_o,
  output logic [STA_W-1:0]   found_station_o,
  output logic [ID_W-1:0]    occupant_id_o
);

  lab_cnt_arr_t      cnt_q;
  logic [REGI_W-1:0] reg_idx;
  logic              res_valid, res_ready;
  result_t           res, out_q;
  logic              out_valid_q;

  // station count registers
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      cnt_q[reg_idx] <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = PDATA_W'(cnt_q[reg_idx]);

  sotu_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .lab_cnt_i       (cnt_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .user_id_i       (user_id_i),
    .lab_number_i    (lab_number_i),
    .station_number_i(station_number_i),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign found_lab_o     = out_q.lab;
  assign found_station_o = out_q.sta;
  assign occupant_id_o   = out_q.occ;

  // checks
  `SOTU_ASSERT_NXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o,
                   "item taken while previous one still in work")
  `SOTU_ASSERT_NXT(a_result_lands, res_valid && res_ready, out_valid_o,
                   "handed result did not reach the output register")
  `SOTU_ASSERT_IMP(a_occ_only_busy, out_valid_o && status_o != STAT_BUSY,
                   occupant_id_o == '0, "occupant reported without busy status")
  `SOTU_ASSERT_IMP(a_miss_no_place,
                   out_valid_o && (status_o == STAT_NOT_FOUND || status_o == STAT_BAD),
                   found_lab_o == '0 && found_station_o == '0,
                   "location reported on a miss or bad location")

endmodule

// File: design/sotu_ram.sv
module sotu_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 17
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/sotu_ctrl.sv
module sotu_ctrl import sotu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lab_cnt_arr_t       lab_cnt_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [ID_W-1:0]    user_id_i,
  input  logic [LAB_W-1:0]   lab_number_i,
  input  logic [STA_W-1:0]   station_number_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output result_t            res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOGIN_CHK,
    S_LOGIN_RD,
    S_SCAN,
    S_DONE
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  logic [1:0]        cmd_q, cmd_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [LAB_W-1:0]  lab_q, lab_d;
  logic [STA_W-1:0]  sta_q, sta_d;
  logic [LABI_W-1:0] it_lab_q, it_lab_d;
  lab_cnt_t          it_sta_q, it_sta_d;
  logic              p_v_q, p_v_d;
  logic [LAB_W-1:0]  p_lab_q, p_lab_d;
  logic [STA_W-1:0]  p_sta_q, p_sta_d;
  result_t           res_q, res_d;
  logic [NUM_SLOTS-1:0] used_q;

  logic              set_en, clr_en;
  logic [ADDR_W-1:0] upd_addr;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_raddr, p_addr, login_addr;
  logic [ID_W-1:0]   ram_rdata;
  lab_cnt_t          login_n, it_n;

  sotu_ram #(
    .DEPTH(NUM_SLOTS),
    .WIDTH(ID_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(login_addr),
    .wdata_i(id_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign login_addr = slot_addr(lab_q, sta_q);
  assign p_addr     = slot_addr(p_lab_q, p_sta_q);
  assign login_n    = stations_in_lab(lab_cnt_i, LABI_W'(lab_q));
  assign it_n       = stations_in_lab(lab_cnt_i, it_lab_q);

  // next state and datapath control
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    id_d      = id_q;
    lab_d     = lab_q;
    sta_d     = sta_q;
    it_lab_d  = it_lab_q;
    it_sta_d  = it_sta_q;
    p_v_d     = 1'b0;
    p_lab_d   = p_lab_q;
    p_sta_d   = p_sta_q;
    res_d     = res_q;
    set_en    = 1'b0;
    clr_en    = 1'b0;
    upd_addr  = login_addr;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = login_addr;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = cmd_i;
          id_d     = user_id_i;
          lab_d    = lab_number_i;
          sta_d    = station_number_i;
          it_lab_d = '0;
          it_sta_d = '0;
          res_d    = '{status: STAT_BAD, default: '0};
          if (cmd_i == CMD_LOGIN) begin
            state_d = S_LOGIN_CHK;
          end else if (cmd_i == CMD_LOGOFF || cmd_i == CMD_SEARCH) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      // range check, then fetch the named slot
      S_LOGIN_CHK: begin
        if (32'(lab_q) >= NUM_LABS || CNT_W'(sta_q) >= login_n) begin
          res_d   = '{status: STAT_BAD, default: '0};
          state_d = S_DONE;
        end else begin
          ram_re  = 1'b1;
          state_d = S_LOGIN_RD;
        end
      end
      // busy or claim the slot
      S_LOGIN_RD: begin
        if (used_q[login_addr]) begin
          res_d = '{status: STAT_BUSY, lab: lab_q, sta: sta_q, occ: ram_rdata};
        end else begin
          ram_we = 1'b1;
          set_en = 1'b1;
          res_d  = '{status: STAT_OK, lab: lab_q, sta: sta_q, occ: '0};
        end
        state_d = S_DONE;
      end
      // one slot read issued per cycle except on a step to the next lab, compared in the next cycle
      S_SCAN: begin
        if (p_v_q && used_q[p_addr] && ram_rdata == id_q) begin
          res_d    = '{status: STAT_OK, lab: p_lab_q, sta: p_sta_q, occ: '0};
          clr_en   = (cmd_q == CMD_LOGOFF);
          upd_addr = p_addr;
          state_d  = S_DONE;
        end else if (32'(it_lab_q) >= NUM_LABS) begin
          if (!p_v_q) begin
            res_d   = '{status: STAT_NOT_FOUND, default: '0};
            state_d = S_DONE;
          end
        end else if (it_sta_q < it_n) begin
          ram_re    = 1'b1;
          ram_raddr = slot_addr(it_lab_q[LAB_W-1:0], it_sta_q[STA_W-1:0]);
          p_v_d     = 1'b1;
          p_lab_d   = it_lab_q[LAB_W-1:0];
          p_sta_d   = it_sta_q[STA_W-1:0];
          it_sta_d  = it_sta_q + 1'b1;
        end else begin
          it_lab_d = it_lab_q + 1'b1;
          it_sta_d = '0;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      p_v_q   <= 1'b0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      p_v_q   <= p_v_d;
      if (set_en) begin
        used_q[upd_addr] <= 1'b1;
      end else if (clr_en) begin
        used_q[upd_addr] <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    id_q     <= id_d;
    lab_q    <= lab_d;
    sta_q    <= sta_d;
    it_lab_q <= it_lab_d;
    it_sta_q <= it_sta_d;
    p_lab_q  <= p_lab_d;
    p_sta_q  <= p_sta_d;
    res_q    <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

// File: tb/station_occupancy_checker.sv
module station_occupancy_checker import sotu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port, watched only
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  // command items
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         cmd_i,
  input  logic [ID_W-1:0]    user_id_i,
  input  logic [LAB_W-1:0]   lab_i,
  input  logic [STA_W-1:0]   station_i,
  // result items
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         status_i,
  input  logic [LAB_W-1:0]   found_lab_i,
  input  logic [STA_W-1:0]   found_station_i,
  input  logic [ID_W-1:0]    occupant_id_i,
  // verdict side
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the lab sizes and the slot table
  lab_cnt_t        lab_size [NUM_REGS];
  logic            slot_taken [NUM_SLOTS];
  logic [ID_W-1:0] slot_owner [NUM_SLOTS];
  result_t         awaited_results [$];
  int              mismatches = 0;

  assign fail_count_o = mismatches;

  // stations usable in a lab, clipped to MAX_STATIONS
  function automatic int usable_stations(int lab);
    int n;
    n = 0;
    if (lab < NUM_REGS && lab < NUM_LABS) begin
      n = int'(lab_size[lab]);
      if (n > MAX_STATIONS) begin
        n = MAX_STATIONS;
      end
    end
    return n;
  endfunction

  // apply one command to the shadow table, return the result it must give
  function automatic result_t apply_command(logic [1:0] cmd, logic [ID_W-1:0] id,
                                            logic [LAB_W-1:0] lab, logic [STA_W-1:0] sta);
    result_t r;
    int      idx;
    bit      hit;
    int      hit_lab;
    int      hit_sta;
    r       = '0;
    hit     = 1'b0;
    hit_lab = 0;
    hit_sta = 0;
    case (cmd)
      CMD_LOGIN: begin
        if (int'(lab) >= NUM_LABS || int'(sta) >= usable_stations(int'(lab))) begin
          r.status = STAT_BAD;
        end else begin
          idx   = int'(lab) * MAX_STATIONS + int'(sta);
          r.lab = lab;
          r.sta = sta;
          if (slot_taken[idx]) begin
            r.status = STAT_BUSY;
            r.occ    = slot_owner[idx];
          end else begin
            slot_taken[idx] = 1'b1;
            slot_owner[idx] = id;
            r.status        = STAT_OK;
          end
        end
      end
      CMD_LOGOFF, CMD_SEARCH: begin
        // first holder in lab order, then station order
        for (int l = 0; l < NUM_LABS && !hit; l++) begin
          for (int s = 0; s < usable_stations(l) && !hit; s++) begin
            idx = l * MAX_STATIONS + s;
            if (slot_taken[idx] && slot_owner[idx] == id) begin
              hit     = 1'b1;
              hit_lab = l;
              hit_sta = s;
            end
          end
        end
        if (!hit) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          if (cmd == CMD_LOGOFF) begin
            slot_taken[hit_lab * MAX_STATIONS + hit_sta] = 1'b0;
          end
          r.status = STAT_OK;
          r.lab    = LAB_W'(hit_lab);
          r.sta    = STA_W'(hit_sta);
        end
      end
      default: begin
        r.status = STAT_BAD;
      end
    endcase
    return r;
  endfunction

  // one field of a result item against its expectation
  function automatic void check_field(string what, logic [ID_W-1:0] want,
                                      logic [ID_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // watch config writes, result items and command items
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        lab_size[i] = '0;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_taken[i] = 1'b0;
        slot_owner[i] = '0;
      end
      awaited_results.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        lab_size[paddr[PADDR_W-1:2]] = pwdata[CNT_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result item with nothing expected, status %0d lab %0d station %0d",
                   $time, status_i, found_lab_i, found_station_i);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", ID_W'(want.status), ID_W'(status_i));
          check_field("found_lab", ID_W'(want.lab), ID_W'(found_lab_i));
          check_field("found_station", ID_W'(want.sta), ID_W'(found_station_i));
          check_field("occupant_id", want.occ, occupant_id_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(apply_command(cmd_i, user_id_i, lab_i, station_i));
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sotu_pkg::*;

  typedef enum int {
    REG_FIRST_LAB  = 0,
    REG_SECOND_LAB = 1,
    REG_THIRD_LAB  = 2,
    REG_FOURTH_LAB = 3
  } lab_reg_e;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int NUM_LAYOUTS      = 8;
  localparam int ITEMS_PER_LAYOUT = 154;
  localparam int SIZE_RANDOM      = -1;
  localparam int ID_POOL_SIZE     = 12;
  localparam int MAX_ID           = (1 << ID_W) - 1;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         cmd_i;
  logic [ID_W-1:0]    user_id_i;
  logic [LAB_W-1:0]   lab_number_i;
  logic [STA_W-1:0]   station_number_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic [LAB_W-1:0]   found_lab_o;
  logic [STA_W-1:0]   found_station_o;
  logic [ID_W-1:0]    occupant_id_o;
  int                 fail_count;
  int                 pending;

  bit                 tx_quiet = 1'b0;
  bit                 rx_quiet = 1'b0;
  int                 items_sent = 0;
  int                 layouts_used = 0;
  int                 lab_setting [NUM_REGS];
  logic [ID_W-1:0]    id_pool [ID_POOL_SIZE];

  // lab sizes per layout, SIZE_RANDOM draws a fresh size
  int layout_sizes [NUM_LAYOUTS][NUM_REGS] = '{
    '{64, 64, 64, 64},
    '{127, 127, 127, 127},
    '{1, 1, 1, 1},
    '{0, 0, 0, 0},
    '{SIZE_RANDOM, SIZE_RANDOM, SIZE_RANDOM, SIZE_RANDOM},
    '{64, 0, 64, 0},
    '{SIZE_RANDOM, SIZE_RANDOM, SIZE_RANDOM, SIZE_RANDOM},
    '{65, 3, 100, 64}
  };

  station_occupancy_table_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .user_id_i        (user_id_i),
    .lab_number_i     (lab_number_i),
    .station_number_i (station_number_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .found_lab_o      (found_lab_o),
    .found_station_o  (found_station_o),
    .occupant_id_o    (occupant_id_o)
  );

  station_occupancy_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .cmd_i           (cmd_i),
    .user_id_i       (user_id_i),
    .lab_i           (lab_number_i),
    .station_i       (station_number_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .found_lab_i     (found_lab_o),
    .found_station_i (found_station_o),
    .occupant_id_i   (occupant_id_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stall before each result item is taken
  initial begin
    int stall;
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 19);
      if (stall == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // register write over the config port, setup then access
  task automatic write_lab_reg(int idx, int value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    lab_setting[idx] = value;
  endtask

  // present one command item and hold it until taken
  task automatic send_item(logic [1:0] cmd, logic [ID_W-1:0] id,
                           logic [LAB_W-1:0] lab, logic [STA_W-1:0] sta);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= cmd;
    user_id_i        <= id;
    lab_number_i     <= lab;
    station_number_i <= sta;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // one random command, mostly aimed at ids and slots in use
  task automatic send_random_item();
    int               pick;
    int               span;
    logic [LAB_W-1:0] lab;
    logic [STA_W-1:0] sta;
    logic [ID_W-1:0]  id;
    pick = $urandom_range(0, 99);
    lab  = LAB_W'($urandom_range(0, 3));
    sta  = STA_W'($urandom_range(0, 63));
    id   = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
    if (pick < 40) begin
      span = lab_setting[lab] > MAX_STATIONS ? MAX_STATIONS : lab_setting[lab];
      if (span > 0 && $urandom_range(0, 9) != 0) begin
        sta = STA_W'($urandom_range(0, span - 1));
      end
      send_item(CMD_LOGIN, id, lab, sta);
    end else if (pick < 63) begin
      send_item(CMD_LOGOFF, id, lab, sta);
    end else if (pick < 85) begin
      send_item(CMD_SEARCH, id, lab, sta);
    end else if (pick < 90) begin
      send_item(CMD_UNKNOWN, ID_W'($urandom_range(0, MAX_ID)), lab, sta);
    end else begin
      // noise: any field any value
      send_item(2'($urandom_range(0, 3)), ID_W'($urandom_range(0, MAX_ID)), lab, sta);
    end
  endtask

  initial begin
    int size;
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid_i       <= 1'b0;
    cmd_i            <= CMD_LOGIN;
    user_id_i        <= '0;
    lab_number_i     <= '0;
    station_number_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: full, single, oversized and empty labs
    write_lab_reg(REG_FIRST_LAB, 64);
    write_lab_reg(REG_SECOND_LAB, 1);
    write_lab_reg(REG_THIRD_LAB, 127);
    write_lab_reg(REG_FOURTH_LAB, 0);
    layouts_used++;
    send_item(CMD_LOGIN, ID_W'(0), 2'd0, 6'd0);
    send_item(CMD_LOGIN, ID_W'(MAX_ID), 2'd2, 6'd63);
    send_item(CMD_LOGIN, ID_W'(99999), 2'd1, 6'd0);
    // station past the lab size, and a lab with no stations
    send_item(CMD_LOGIN, ID_W'(42), 2'd1, 6'd1);
    send_item(CMD_LOGIN, ID_W'(42), 2'd3, 6'd0);
    // occupied slots report their occupant
    send_item(CMD_LOGIN, ID_W'(5), 2'd0, 6'd0);
    send_item(CMD_LOGIN, ID_W'(7), 2'd2, 6'd63);
    send_item(CMD_SEARCH, ID_W'(MAX_ID), 2'd3, 6'd17);
    send_item(CMD_SEARCH, ID_W'(12345), 2'd0, 6'd0);
    send_item(CMD_UNKNOWN, ID_W'(MAX_ID), 2'd3, 6'd63);
    // logoff ignores the location fields
    send_item(CMD_LOGOFF, ID_W'(0), 2'd3, 6'd63);
    send_item(CMD_LOGOFF, ID_W'(0), 2'd0, 6'd0);
    // the first holder in scan order wins
    send_item(CMD_LOGIN, ID_W'(77), 2'd0, 6'd63);
    send_item(CMD_LOGIN, ID_W'(77), 2'd0, 6'd5);
    send_item(CMD_SEARCH, ID_W'(77), 2'd1, 6'd42);
    send_item(CMD_LOGOFF, ID_W'(77), 2'd2, 6'd21);
    send_item(CMD_SEARCH, ID_W'(77), 2'd0, 6'd0);
    send_item(CMD_LOGOFF, ID_W'(99999), 2'd1, 6'd0);
    drain_results();

    // random part, one layout of lab sizes after another
    for (int p = 0; p < NUM_LAYOUTS; p++) begin
      repeat (8) @(posedge clk_i);
      for (int r = 0; r < NUM_REGS; r++) begin
        size = layout_sizes[p][r] == SIZE_RANDOM ? $urandom_range(0, 127) : layout_sizes[p][r];
        write_lab_reg(r, size);
      end
      layouts_used++;
      for (int k = 0; k < ID_POOL_SIZE; k++) begin
        id_pool[k] = k < 4 ? ID_W'($urandom_range(99990, MAX_ID))
                           : ID_W'($urandom_range(0, MAX_ID));
      end
      tx_quiet = (p % 3 == 2);
      rx_quiet = (p % 4 == 3);
      for (int n = 0; n < ITEMS_PER_LAYOUT; n++) begin
        // hold off now and then until the table has answered everything
        if (n == ITEMS_PER_LAYOUT / 2 && p % 2 == 0) begin
          drain_results();
        end
        send_random_item();
      end
      drain_results();
    end

    // let any stray result item show up
    repeat (300) @(posedge clk_i);
    $display("covered %0d command items over %0d lab size layouts", items_sent, layouts_used);
    $display("with logins, logoffs, searches, bad locations and unknown commands mixed in");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
